@@ hw/rtl/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types, fixed-point constants and datapath operation codes for the
// pulse peak rate detector.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QONE      = 1 << FRAC_BITS;

  localparam int SAMPLE_W  = 18;
  localparam int NORM_W    = 20;
  localparam int BASE_W    = SAMPLE_W + FRAC_BITS;
  localparam int PEAK_W    = NORM_W + FRAC_BITS;
  localparam int K_W       = FRAC_BITS + 1;
  localparam int MUL_A_W   = PEAK_W + 1;
  localparam int PROD_W    = MUL_A_W + K_W + 1;
  localparam int QM_W      = PROD_W - FRAC_BITS;
  localparam int RATE_W    = 24;
  localparam int CNT_W     = 5;

  // coefficients, round(x * ONE)
  localparam logic [K_W-1:0] K_SETTLE  = K_W'(QONE - (QONE + 50) / 100);
  localparam logic [K_W-1:0] K_TRACK   = K_W'((QONE + 500) / 1000);
  localparam logic [K_W-1:0] K_DROP    = K_W'((9 * QONE + 5) / 10);
  localparam logic [K_W-1:0] K_DECAY   = K_W'((5 * QONE + 50) / 100);
  localparam logic [K_W-1:0] K_THRESH  = K_W'((7 * QONE + 5) / 10);
  localparam logic [K_W-1:0] K_ALPHA   = K_W'((2 * QONE + 5) / 10);

  // 60000 * 256
  localparam logic [RATE_W-1:0] RATE_NUM = 24'd15360000;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_RESET  = 2'd1;
  localparam logic [1:0] MODE_SETTLE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_GAP    = 3'd0;
  localparam logic [2:0] CFG_SETTLE_WIN = 3'd1;
  localparam logic [2:0] CFG_MAX_INTV   = 3'd2;
  localparam logic [2:0] CFG_MIN_BPM    = 3'd3;
  localparam logic [2:0] CFG_MAX_BPM    = 3'd4;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_MODE      = 4'd1;
  localparam logic [3:0] OP_SET_MUL   = 4'd2;
  localparam logic [3:0] OP_SET_UPD   = 4'd3;
  localparam logic [3:0] OP_NORM      = 4'd4;
  localparam logic [3:0] OP_PEAK      = 4'd5;
  localparam logic [3:0] OP_DECAY_MUL = 4'd6;
  localparam logic [3:0] OP_DECAY_UPD = 4'd7;
  localparam logic [3:0] OP_THR_MUL   = 4'd8;
  localparam logic [3:0] OP_DECIDE    = 4'd9;
  localparam logic [3:0] OP_RATE      = 4'd10;
  localparam logic [3:0] OP_AVG_MUL   = 4'd11;
  localparam logic [3:0] OP_AVG_UPD   = 4'd12;
  localparam logic [3:0] OP_TRK_MUL   = 4'd13;
  localparam logic [3:0] OP_TRK_UPD   = 4'd14;
  localparam logic [3:0] OP_RESULT    = 4'd15;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample_value;
    logic [31:0]         time_ms;
    logic                settled_value;
  } in_item_t;

  typedef struct packed {
    logic              beat_detected;
    logic [RATE_W-1:0] bpm_instant_q8;
    logic [9:0]        bpm_average;
    logic              baseline_settled;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       settled;
    logic       decay_need;
    logic       cand;
    logic       intv_ok;
    logic       div_done;
    logic       in_range;
    logic       avg_zero;
  } status_t;

endpackage

@@ hw/rtl/ppd_div.sv @@
// ----------------------------------------------------------------------------
// ppd_div
// Restoring divider, one quotient bit per cycle: RATE_NUM / divisor.
// ----------------------------------------------------------------------------
module ppd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [15:0]                 divisor_i,
  output logic                        done_o,
  output logic [ppd_pkg::RATE_W-1:0]  quot_o
);
  import ppd_pkg::*;

  logic [RATE_W-1:0] dvd_q;
  logic [15:0]       rem_q;
  logic [15:0]       den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [16:0]       shifted;
  logic              ge;
  logic [16:0]       diff;

  assign shifted = {rem_q, dvd_q[RATE_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RATE_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= RATE_NUM;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RATE_W-2:0], ge};
      rem_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ hw/rtl/ppd_dp.sv @@
// ----------------------------------------------------------------------------
// ppd_dp
// Detector datapath: configuration, state registers, shared multiplier,
// divider and result register.
// ----------------------------------------------------------------------------
module ppd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppd_pkg::cmd_t       cmd_i,
  output ppd_pkg::status_t    status_o,
  input  ppd_pkg::in_item_t   in_data_i,
  output ppd_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import ppd_pkg::*;

  // configuration
  logic [11:0] gap_q;
  logic [15:0] win_q;
  logic [15:0] max_intv_q;
  logic [7:0]  min_bpm_q;
  logic [9:0]  max_bpm_q;

  // item
  logic [1:0]          mode_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [31:0]         time_q;
  logic                setv_q;

  // detector state
  logic [BASE_W-1:0]        base_q;
  logic                     settled_q;
  logic [31:0]              sst_q;
  logic signed [NORM_W-1:0] prev_q;
  logic                     rising_q;
  logic [31:0]              lpt_q;
  logic signed [PEAK_W-1:0] peak_q;
  logic [RATE_W-1:0]        inst_q;
  logic [RATE_W-1:0]        avg_q;

  // work registers
  logic signed [NORM_W-1:0] norm_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     beat_q;
  out_item_t                out_q;

  logic [BASE_W-1:0]         target;
  logic signed [BASE_W:0]    base_diff;
  logic signed [BASE_W:0]    norm_fl;
  logic signed [NORM_W-1:0]  norm_c;
  logic signed [PEAK_W-1:0]  normq;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [K_W-1:0]            mul_k;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [QM_W-1:0]    qm;
  logic signed [QM_W-1:0]    normq_x;
  logic signed [QM_W-1:0]    thr_fl;
  logic signed [QM_W-1:0]    thr;
  logic signed [QM_W-1:0]    norm_x;
  logic                      rise_new;
  logic [31:0]               intv;
  logic                      cand_c;
  logic                      intv_ok_c;
  logic                      in_range_c;
  logic                      div_start;
  logic                      div_done;
  logic [RATE_W-1:0]         quot;

  assign target    = {sample_q, {FRAC_BITS{1'b0}}};
  assign base_diff = $signed({1'b0, target}) - $signed({1'b0, base_q});
  assign norm_fl   = base_diff >>> FRAC_BITS;
  // truncate toward zero
  assign norm_c    = NORM_W'(norm_fl) +
                     NORM_W'(base_diff[BASE_W] && (|base_diff[FRAC_BITS-1:0]));
  assign normq     = {norm_q, {FRAC_BITS{1'b0}}};

  always_comb begin
    mul_a = '0;
    mul_k = '0;
    case (cmd_i.op)
      OP_SET_MUL: begin
        mul_a = MUL_A_W'(base_diff);
        mul_k = K_SETTLE;
      end
      OP_TRK_MUL: begin
        mul_a = MUL_A_W'(base_diff);
        mul_k = K_TRACK;
      end
      OP_NORM: begin
        mul_a = MUL_A_W'(peak_q);
        mul_k = K_DROP;
      end
      OP_THR_MUL: begin
        mul_a = MUL_A_W'(peak_q);
        mul_k = K_THRESH;
      end
      OP_DECAY_MUL: begin
        mul_a = MUL_A_W'(normq) - MUL_A_W'(peak_q);
        mul_k = K_DECAY;
      end
      OP_AVG_MUL: begin
        mul_a = $signed(MUL_A_W'(inst_q)) - $signed(MUL_A_W'(avg_q));
        mul_k = K_ALPHA;
      end
      default: begin
        mul_a = '0;
        mul_k = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * $signed({1'b0, mul_k});
  assign qm      = prod_q[PROD_W-1:FRAC_BITS];
  assign normq_x = QM_W'(normq);
  assign thr_fl  = qm >>> FRAC_BITS;
  assign thr     = thr_fl + QM_W'(qm[QM_W-1] && (|qm[FRAC_BITS-1:0]));
  assign norm_x  = QM_W'(norm_q);

  assign rise_new   = norm_q > prev_q;
  assign intv       = time_q - lpt_q;
  assign cand_c     = rising_q && !rise_new && (norm_x > thr) && (intv > {20'd0, gap_q});
  assign intv_ok_c  = (intv != 32'd0) && (intv < {16'd0, max_intv_q});
  assign in_range_c = ({2'b0, quot} >= {10'd0, min_bpm_q, 8'd0}) &&
                      ({2'b0, quot} <= {8'd0, max_bpm_q, 8'd0});
  assign div_start  = (cmd_i.op == OP_DECIDE) && cand_c && intv_ok_c;

  ppd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (intv[15:0]),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q      <= 12'd300;
      win_q      <= 16'd5000;
      max_intv_q <= 16'd3000;
      min_bpm_q  <= 8'd20;
      max_bpm_q  <= 10'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_GAP:    gap_q      <= cfg_data_i[11:0];
        CFG_SETTLE_WIN: win_q      <= cfg_data_i;
        CFG_MAX_INTV:   max_intv_q <= cfg_data_i;
        CFG_MIN_BPM:    min_bpm_q  <= cfg_data_i[7:0];
        CFG_MAX_BPM:    max_bpm_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      settled_q <= 1'b0;
      sst_q     <= '0;
      prev_q    <= '0;
      rising_q  <= 1'b0;
      lpt_q     <= '0;
      peak_q    <= '0;
      inst_q    <= '0;
      avg_q     <= '0;
      beat_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        beat_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_MODE: begin
          case (mode_q)
            MODE_RESET: begin
              base_q    <= '0;
              settled_q <= 1'b0;
              sst_q     <= time_q;
              peak_q    <= '0;
            end
            MODE_SETTLE: settled_q <= setv_q;
            default: ;
          endcase
        end
        OP_SET_UPD: begin
          base_q <= base_q + qm[BASE_W-1:0];
          if ((time_q - sst_q) >= {16'd0, win_q}) begin
            settled_q <= 1'b1;
          end
        end
        OP_PEAK: begin
          if (normq > peak_q) begin
            peak_q <= normq;
          end
        end
        OP_DECAY_UPD: peak_q <= peak_q + qm[PEAK_W-1:0];
        OP_DECIDE: begin
          rising_q <= rise_new;
          if (cand_c) begin
            lpt_q <= time_q;
          end
        end
        OP_RATE: begin
          inst_q <= quot;
          if (in_range_c && (avg_q == '0)) begin
            avg_q  <= quot;
            beat_q <= 1'b1;
          end
        end
        OP_AVG_UPD: begin
          avg_q  <= avg_q + qm[RATE_W-1:0];
          beat_q <= 1'b1;
        end
        OP_TRK_UPD: begin
          base_q <= base_q + qm[BASE_W-1:0];
          prev_q <= norm_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      mode_q   <= in_data_i.mode;
      sample_q <= in_data_i.sample_value;
      time_q   <= in_data_i.time_ms;
      setv_q   <= in_data_i.settled_value;
    end
    if (cmd_i.op == OP_NORM) begin
      norm_q <= norm_c;
    end
    if (cmd_i.op == OP_RESULT) begin
      out_q.beat_detected    <= beat_q;
      out_q.bpm_instant_q8   <= inst_q;
      out_q.bpm_average      <= avg_q[17:8];
      out_q.baseline_settled <= settled_q;
    end
  end

  assign status_o.mode       = mode_q;
  assign status_o.settled    = settled_q;
  assign status_o.decay_need = !(normq > peak_q) && (normq_x < qm);
  assign status_o.cand       = cand_c;
  assign status_o.intv_ok    = intv_ok_c;
  assign status_o.div_done   = div_done;
  assign status_o.in_range   = in_range_c;
  assign status_o.avg_zero   = (avg_q == '0);
  assign out_data_o          = out_q;

endmodule

@@ hw/rtl/ppd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppd_ctrl
// Sequencer: steps the datapath through one item and owns both handshakes.
// ----------------------------------------------------------------------------
module ppd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ppd_pkg::cmd_t     cmd_o,
  input  ppd_pkg::status_t  status_i
);
  import ppd_pkg::*;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_DISPATCH  = 5'd1;
  localparam logic [4:0] ST_SET_MUL   = 5'd2;
  localparam logic [4:0] ST_SET_UPD   = 5'd3;
  localparam logic [4:0] ST_NORM      = 5'd4;
  localparam logic [4:0] ST_PEAK      = 5'd5;
  localparam logic [4:0] ST_DECAY_MUL = 5'd6;
  localparam logic [4:0] ST_DECAY_UPD = 5'd7;
  localparam logic [4:0] ST_THR_MUL   = 5'd8;
  localparam logic [4:0] ST_DECIDE    = 5'd9;
  localparam logic [4:0] ST_DIV       = 5'd10;
  localparam logic [4:0] ST_RATE      = 5'd11;
  localparam logic [4:0] ST_AVG_MUL   = 5'd12;
  localparam logic [4:0] ST_AVG_UPD   = 5'd13;
  localparam logic [4:0] ST_TRK_MUL   = 5'd14;
  localparam logic [4:0] ST_TRK_UPD   = 5'd15;
  localparam logic [4:0] ST_DONE      = 5'd16;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.mode == MODE_SAMPLE) begin
          state_d = status_i.settled ? ST_NORM : ST_SET_MUL;
        end else begin
          cmd_o.op = OP_MODE;
          state_d  = ST_DONE;
        end
      end
      ST_SET_MUL: begin
        cmd_o.op = OP_SET_MUL;
        state_d  = ST_SET_UPD;
      end
      ST_SET_UPD: begin
        cmd_o.op = OP_SET_UPD;
        state_d  = ST_DONE;
      end
      ST_NORM: begin
        cmd_o.op = OP_NORM;
        state_d  = ST_PEAK;
      end
      ST_PEAK: begin
        cmd_o.op = OP_PEAK;
        state_d  = status_i.decay_need ? ST_DECAY_MUL : ST_THR_MUL;
      end
      ST_DECAY_MUL: begin
        cmd_o.op = OP_DECAY_MUL;
        state_d  = ST_DECAY_UPD;
      end
      ST_DECAY_UPD: begin
        cmd_o.op = OP_DECAY_UPD;
        state_d  = ST_THR_MUL;
      end
      ST_THR_MUL: begin
        cmd_o.op = OP_THR_MUL;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        state_d  = (status_i.cand && status_i.intv_ok) ? ST_DIV : ST_TRK_MUL;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_RATE;
        end
      end
      ST_RATE: begin
        cmd_o.op = OP_RATE;
        if (!status_i.in_range) begin
          state_d = ST_TRK_MUL;
        end else if (status_i.avg_zero) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_AVG_MUL;
        end
      end
      ST_AVG_MUL: begin
        cmd_o.op = OP_AVG_MUL;
        state_d  = ST_AVG_UPD;
      end
      ST_AVG_UPD: begin
        cmd_o.op = OP_AVG_UPD;
        state_d  = ST_DONE;
      end
      ST_TRK_MUL: begin
        cmd_o.op = OP_TRK_MUL;
        state_d  = ST_TRK_UPD;
      end
      ST_TRK_UPD: begin
        cmd_o.op = OP_TRK_UPD;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = OP_RESULT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_RESULT) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pulse_peak_rate_detector.sv @@
// ----------------------------------------------------------------------------
// pulse_peak_rate_detector
// Beat detector for timestamped optical pulse samples with rate averaging.
// ----------------------------------------------------------------------------
// One item is processed at a time and gives one result beat. A mode item
// passes accept, dispatch and done; a settling sample adds the baseline
// multiply and update; a settled sample runs normalise, peak, threshold and
// decide, with decay steps when the peak maximum decays. A beat candidate
// waits for the 24-step serial divider that turns the peak interval into a
// rate. How long an item takes depends on peak decay and on the path taken
// after the rate check. A single shared multiplier does every fixed-point
// weighting, one product per cycle. The result sits in an output register,
// so a new item is taken while the last result waits. A result that finds
// the register still stalled holds the sequencer until it frees.
module pulse_peak_rate_detector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ppd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ppd_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import ppd_pkg::*;

  cmd_t    cmd;
  status_t status;

  ppd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ppd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a beat without going busy");

  a_beat_needs_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.beat_detected) |-> out_data_o.baseline_settled)
    else $error("beat reported while baseline not settled");

  a_beat_has_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.beat_detected) |-> (out_data_o.bpm_instant_q8 != '0))
    else $error("beat reported with zero instantaneous rate");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse peak rate detector. Synthetic pulse trains
// and random items are driven through the valid/stall channel, and each result
// beat is checked against a fixed-point beat and rate predictor kept here.
// ----------------------------------------------------------------------------
module tb;
  import ppd_pkg::*;

  localparam longint ONE_L    = 64'sd1 << FRAC_BITS;
  localparam longint W_SETTLE = ONE_L - (ONE_L + 50) / 100;
  localparam longint W_TRACK  = (ONE_L + 500) / 1000;
  localparam longint W_DROP   = (9 * ONE_L + 5) / 10;
  localparam longint W_DECAY  = (5 * ONE_L + 50) / 100;
  localparam longint W_THRESH = (7 * ONE_L + 5) / 10;
  localparam longint W_ALPHA  = (2 * ONE_L + 5) / 10;
  localparam int     DRAIN    = 60;
  // mode code with no function
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk, rst_n;
  logic in_valid = 1'b0;
  logic in_stall, out_valid;
  logic out_stall = 1'b0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_data;

  pulse_peak_rate_detector u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // predictor configuration and state
  logic [31:0] gap_ms, settle_ms, max_intv_ms, lo_bpm, hi_bpm;
  longint base_lvl = 0;
  longint peak_max = 0;
  longint prev_norm = 0;
  longint inst_rate = 0;
  longint avg_rate = 0;
  logic settled = 1'b0;
  logic rising = 1'b0;
  logic [31:0] settle_t0 = '0;
  logic [31:0] last_peak_t = '0;

  in_item_t  pending_items[$];
  out_item_t expected_beats[$];
  int errors = 0;
  int send_idle, recv_idle;
  int acc_cnt = 0;
  int drv_cnt = 0;

  function automatic longint qscale(longint x, longint c);
    return (x * c) >>> FRAC_BITS;
  endfunction

  function automatic out_item_t predict_beat(in_item_t it);
    longint tgt, nrm, nq, thr;
    logic was, beat;
    logic [31:0] span;
    out_item_t r;
    beat = 1'b0;
    case (it.mode)
      MODE_SAMPLE: begin
        tgt = longint'(it.sample_value) * ONE_L;
        if (!settled) begin
          base_lvl = base_lvl + qscale(tgt - base_lvl, W_SETTLE);
          span = it.time_ms - settle_t0;
          if (span >= settle_ms) settled = 1'b1;
        end else begin
          nrm = (tgt - base_lvl) / ONE_L;
          nq = nrm * ONE_L;
          if (nq > peak_max) peak_max = nq;
          else if (nq < qscale(peak_max, W_DROP))
            peak_max = peak_max + qscale(nq - peak_max, W_DECAY);
          was = rising;
          rising = nrm > prev_norm;
          thr = qscale(peak_max, W_THRESH) / ONE_L;
          span = it.time_ms - last_peak_t;
          if (was && !rising && nrm > thr && span > gap_ms) begin
            last_peak_t = it.time_ms;
            if (span != 0 && span < max_intv_ms) begin
              inst_rate = longint'(32'd15360000 / span);
              if (inst_rate >= longint'(lo_bpm) * 256 && inst_rate <= longint'(hi_bpm) * 256)
              begin
                if (avg_rate == 0) avg_rate = inst_rate;
                else avg_rate = avg_rate + qscale(inst_rate - avg_rate, W_ALPHA);
                beat = 1'b1;
              end
            end
          end
          if (!beat) begin
            prev_norm = nrm;
            base_lvl = base_lvl + qscale(tgt - base_lvl, W_TRACK);
          end
        end
      end
      MODE_RESET: begin
        base_lvl = 0;
        settled = 1'b0;
        settle_t0 = it.time_ms;
        peak_max = 0;
      end
      MODE_SETTLE: settled = it.settled_value;
      default: ;
    endcase
    r.beat_detected = beat;
    r.bpm_instant_q8 = inst_rate[23:0];
    r.bpm_average = avg_rate[17:8];
    r.baseline_settled = settled;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // accept side and prediction
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_beats.push_back(predict_beat(in_data));
      acc_cnt++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || (acc_cnt != drv_cnt)) begin
        drv_cnt = acc_cnt;
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (out_data.beat_detected !== e.beat_detected) begin
          $error("beat_detected exp %0d got %0d", e.beat_detected, out_data.beat_detected);
          errors++;
        end
        if (out_data.bpm_instant_q8 !== e.bpm_instant_q8) begin
          $error("bpm_instant_q8 exp %0d got %0d", e.bpm_instant_q8, out_data.bpm_instant_q8);
          errors++;
        end
        if (out_data.bpm_average !== e.bpm_average) begin
          $error("bpm_average exp %0d got %0d", e.bpm_average, out_data.bpm_average);
          errors++;
        end
        if (out_data.baseline_settled !== e.baseline_settled) begin
          $error("baseline_settled exp %0d got %0d", e.baseline_settled,
                 out_data.baseline_settled);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MIN_GAP:    gap_ms = 32'(val[11:0]);
      CFG_SETTLE_WIN: settle_ms = 32'(val);
      CFG_MAX_INTV:   max_intv_ms = 32'(val);
      CFG_MIN_BPM:    lo_bpm = 32'(val[7:0]);
      CFG_MAX_BPM:    hi_bpm = 32'(val[9:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(logic [1:0] m, logic [17:0] s, logic [31:0] t, logic sv);
    in_item_t it;
    it.mode = m;
    it.sample_value = s;
    it.time_ms = t;
    it.settled_value = sv;
    pending_items.push_back(it);
  endtask

  // baseline reset followed by a noisy triangle pulse train with occasional settle items
  task automatic push_pulse_train(int n);
    logic [31:0] t;
    int lvl, amp, per, pos, v;
    t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
    lvl = $urandom_range(200000);
    amp = $urandom_range(200, 60000);
    per = $urandom_range(20, 90);
    push_item(MODE_RESET, 18'($urandom), t, 1'($urandom));
    for (int i = 0; i < n; i++) begin
      t += $urandom_range(4, 16);
      pos = i % per;
      v = lvl + amp * ((pos < per / 2) ? pos : per - pos) / per + $urandom_range(40);
      if (v > 262143) v = 262143;
      if ($urandom_range(60) == 0) push_item(MODE_SETTLE, 18'($urandom), t, 1'($urandom));
      else push_item(MODE_SAMPLE, v[17:0], t, 1'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    logic [15:0] cfg_sets[6][5];
    cfg_sets = '{'{300, 200, 3000, 20, 255}, '{1, 0, 65535, 0, 1023},
                 '{2999, 65535, 1, 255, 0}, '{150, 50, 2000, 40, 200},
                 '{400, 0, 65535, 0, 1023}, '{250, 100, 3000, 30, 300}};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    gap_ms = 300; settle_ms = 5000; max_intv_ms = 3000; lo_bpm = 20; hi_bpm = 255;
    send_idle = 23;
    recv_idle = 48;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every mode, unused mode
    push_item(MODE_SAMPLE, 18'h3FFFF, 32'd0, 1'b0);
    push_item(MODE_SAMPLE, 18'h0, 32'hFFFF_FFFF, 1'b1);
    push_item(MODE_SPARE, 18'h3FFFF, 32'hFFFF_FFFF, 1'b1);
    push_item(MODE_SETTLE, 18'h0, 32'd0, 1'b1);
    push_item(MODE_SAMPLE, 18'h3FFFF, 32'd10, 1'b0);
    push_item(MODE_SAMPLE, 18'h0, 32'd20, 1'b0);
    push_item(MODE_SETTLE, 18'h3FFFF, 32'd30, 1'b0);
    push_item(MODE_RESET, 18'h0, 32'hFFFF_FF00, 1'b0);
    push_item(MODE_SAMPLE, 18'h20000, 32'd5000, 1'b1);
    push_item(MODE_SETTLE, 18'h0, 32'd0, 1'b1);
    push_pulse_train(60);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p == 1) begin send_idle = 48; recv_idle = 23; end
      if (p == 3) begin send_idle = 0; recv_idle = 0; end
      for (int r = 0; r < 5; r++) write_reg(r[2:0], cfg_sets[p][r]);
      for (int k = 0; k < 3; k++) begin
        push_pulse_train($urandom_range(15, 30));
        repeat ($urandom_range(2, 6))
          push_item(2'($urandom), 18'($urandom), $urandom, 1'($urandom));
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ pulse_peak_rate_detector.f @@
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_div.sv
hw/rtl/ppd_dp.sv
hw/rtl/ppd_ctrl.sv
hw/rtl/pulse_peak_rate_detector.sv
tb/tb.sv
